>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file lpm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define LPM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lpm check failed");

// clocked assertion that also holds through reset
`define LPM_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lpm reset check failed");

`endif

>>> rtl/core/lpm_pkg.sv
// types, constants and helpers for the ipv6 longest prefix match block
package lpm_pkg;

	localparam int ADDR_W       = 128;
	localparam int HALF_W       = 64;
	localparam int LEN_W        = 8;
	localparam int METRIC_W     = 16;
	localparam int HOP_W        = 16;
	localparam int ENTRY_SLOT_W = 4;
	localparam int MAX_SLOTS    = 2 ** ENTRY_SLOT_W;
	localparam int SUM_W        = LEN_W + 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// one stored route, network already masked to its length
	typedef struct packed {
		logic [ADDR_W-1:0]   net;
		logic [LEN_W-1:0]    len;
		logic [METRIC_W-1:0] metric;
		logic [HOP_W-1:0]    hop;
	} route_t;

	// running best of a scan, as seen by the compare unit
	typedef struct packed {
		logic                found;
		logic [LEN_W-1:0]    len;
		logic [METRIC_W-1:0] metric;
	} best_t;

	// table write request
	typedef struct packed {
		logic en;
		logic set;
	} wr_req_t;

	// leading-ones mask of len bits over the full address
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		for (int i = 0; i < ADDR_W; i++) begin
			m[i] = (SUM_W'(len) + SUM_W'(i)) >= SUM_W'(ADDR_W);
		end
		return m;
	endfunction

endpackage

>>> rtl/core/lpm_table.sv
// route table storage with valid bits and a registered read port
module lpm_table
	import lpm_pkg::*;
#(
	parameter int DEPTH  = 16,
	parameter int SLOT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wr_req_t           wr,
	input  logic [SLOT_W-1:0] wr_addr,
	input  route_t            wr_row,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output route_t            rd_row,
	output logic              rd_valid
);

	route_t           mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	route_t           rd_row_q;
	logic             rd_valid_q;

	// payload store, no reset
	always_ff @(posedge clk) begin
		if (wr.en && wr.set) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= wr.set;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_row   = rd_row_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> rtl/core/lpm_cmp.sv
// shared match and preference compare, one table row per use
module lpm_cmp
	import lpm_pkg::*;
(
	input  logic [ADDR_W-1:0] dest,
	input  route_t            row,
	input  logic              row_valid,
	input  best_t             best,
	output logic              take
);

	logic covers;
	logic better;

	assign covers = ((dest & prefix_mask(row.len)) == row.net);

	// longer prefix first, then lower metric; ties keep the earlier slot
	assign better = !best.found || (row.len > best.len) ||
		((row.len == best.len) && (row.metric < best.metric));

	assign take = row_valid && covers && better;

endmodule

>>> rtl/core/ipv6_longest_prefix_match.sv
// top level of the ipv6 longest prefix match route table
//
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------------
// command   | start / busy        | op entry_slot entry_enable addr_high addr_low
//           |                     | route_length route_metric route_hop
// result    | done (one cycle)    | hit hop_out length_out metric_out slot_out
//
// on a write the table is written at the accept edge and done shows in the next cycle
// a lookup scans N = min(ROUTE_ENTRIES, 16) rows, one row per cycle through the single
// table read port and the shared compare unit, then passes ST_FINISH and ST_DONE
// reset clears the valid bits, the read valid flag and the sequencer only; the table payload is left as is
// the receiver cannot stall: done is high for exactly one cycle per transaction
module ipv6_longest_prefix_match
	import lpm_pkg::*;
#(
	parameter int ROUTE_ENTRIES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    op,
	input  logic [ENTRY_SLOT_W-1:0] entry_slot,
	input  logic                    entry_enable,
	input  logic [HALF_W-1:0]       addr_high,
	input  logic [HALF_W-1:0]       addr_low,
	input  logic [LEN_W-1:0]        route_length,
	input  logic [METRIC_W-1:0]     route_metric,
	input  logic [HOP_W-1:0]        route_hop,
	output logic                    done,
	output logic                    hit,
	output logic [HOP_W-1:0]        hop_out,
	output logic [LEN_W-1:0]        length_out,
	output logic [METRIC_W-1:0]     metric_out,
	output logic [ENTRY_SLOT_W-1:0] slot_out
);

	// only the slots that the 4-bit slot field can reach are ever valid
	localparam int WR_SLOTS = (ROUTE_ENTRIES < MAX_SLOTS) ? ROUTE_ENTRIES : MAX_SLOTS;
	localparam int SLOT_W   = (WR_SLOTS > 1) ? $clog2(WR_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WR_SLOTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [ADDR_W-1:0]   dest_q;
	logic                vld_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic                found_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [METRIC_W-1:0] best_metric_q;
	logic [HOP_W-1:0]    best_hop_q;
	logic [SLOT_W-1:0]   best_idx_q;

	logic                accept;
	logic                slot_ok;
	logic [LEN_W-1:0]    len_sat;
	wr_req_t             wr;
	route_t              wr_row;
	route_t              rd_row;
	logic                rd_valid;
	best_t               best;
	logic                take;

	assign accept = start && !busy;

	// write path: out-of-range slots are dropped, long prefixes saturate at 128
	assign slot_ok = (32'(entry_slot) < 32'(WR_SLOTS));
	assign len_sat = (route_length > MAX_LEN) ? MAX_LEN : route_length;

	assign wr.en  = accept && (op == OP_WRITE) && slot_ok;
	assign wr.set = entry_enable;

	assign wr_row.net    = {addr_high, addr_low} & prefix_mask(len_sat);
	assign wr_row.len    = len_sat;
	assign wr_row.metric = route_metric;
	assign wr_row.hop    = route_hop;

	lpm_table #(
		.DEPTH  (WR_SLOTS),
		.SLOT_W (SLOT_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_addr  (entry_slot[SLOT_W-1:0]),
		.wr_row   (wr_row),
		.rd_en    (state_q == ST_SCAN),
		.rd_addr  (scan_q),
		.rd_row   (rd_row),
		.rd_valid (rd_valid)
	);

	// one row a cycle through the shared compare unit, in the cycle after its read
	assign best.found  = found_q;
	assign best.len    = best_len_q;
	assign best.metric = best_metric_q;

	lpm_cmp u_cmp (
		.dest      (dest_q),
		.row       (rd_row),
		.row_valid (vld_s1 && rd_valid),
		.best      (best),
		.take      (take)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						scan_q  <= '0;
						state_q <= (op == OP_LOOKUP) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + SLOT_W'(1);
					if (scan_q == LAST_SLOT) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// last row is compared in this cycle
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// lookup destination and running best, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept) begin
			dest_q <= {addr_high, addr_low};
		end
		if (take) begin
			best_len_q    <= rd_row.len;
			best_metric_q <= rd_row.metric;
			best_hop_q    <= rd_row.hop;
			best_idx_q    <= idx_s1;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// writes and misses report all zero
	assign hit        = found_q;
	assign hop_out    = found_q ? best_hop_q : '0;
	assign length_out = found_q ? best_len_q : '0;
	assign metric_out = found_q ? best_metric_q : '0;
	assign slot_out   = found_q ? ENTRY_SLOT_W'(best_idx_q) : '0;

endmodule

>>> rtl/core/lpm_checker.sv
// port-level checks for the ipv6 longest prefix match block, with bind
`include "assert_macros.svh"

module lpm_checker
	import lpm_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    op,
	input logic                    done,
	input logic                    hit,
	input logic [HOP_W-1:0]        hop_out,
	input logic [LEN_W-1:0]        length_out,
	input logic [METRIC_W-1:0]     metric_out,
	input logic [ENTRY_SLOT_W-1:0] slot_out
);

	`LPM_ASSERT(a_write_done_next, clk, arst_n, (start && !busy && op == OP_WRITE) |=> (done && !hit))
	`LPM_ASSERT(a_done_single, clk, arst_n, done |=> !done)
	`LPM_ASSERT(a_miss_zero, clk, arst_n, (done && !hit) |-> (hop_out == '0 && length_out == '0 && metric_out == '0 && slot_out == '0))
	`LPM_ASSERT(a_hit_len, clk, arst_n, (done && hit) |-> (length_out <= MAX_LEN))
	// while reset stays asserted, the sequencer is known to sit idle
	`LPM_ASSERT_RST(a_reset_quiet, clk, (!arst_n && $past(!arst_n)) |-> (!done && !busy))

endmodule

bind ipv6_longest_prefix_match lpm_checker u_lpm_checker (.*);
